// File: rtl/core/wpsg_pkg.sv
package wpsg_pkg;

    // Register addresses of the bus write
    localparam logic [3:0] ADDR_SELECT    = 4'd0;
    localparam logic [3:0] ADDR_MAIN_BAL  = 4'd1;
    localparam logic [3:0] ADDR_FREQ_LO   = 4'd2;
    localparam logic [3:0] ADDR_FREQ_HI   = 4'd3;
    localparam logic [3:0] ADDR_CONTROL   = 4'd4;
    localparam logic [3:0] ADDR_CHAN_BAL  = 4'd5;
    localparam logic [3:0] ADDR_WAVE_DATA = 4'd6;
    localparam logic [3:0] ADDR_NOISE     = 4'd7;
    localparam logic [3:0] ADDR_LFO_RATE  = 4'd8;
    localparam logic [3:0] ADDR_LFO_CTRL  = 4'd9;

    // Noise reload is the inverted low five bits of the noise write data shifted up by this much
    localparam int NOISE_SHIFT = 7;

    typedef struct packed {
        logic [3:0] reg_address;
        logic [7:0] write_data;
    } req_word_t;

    typedef struct packed {
        logic [2:0]  selected_channel;
        logic        channel_touched;
        logic [4:0]  current_sample;
        logic [4:0]  wave_index;
        logic [11:0] period_value;
        logic [4:0]  channel_volume;
        logic        play_enable;
        logic        direct_mode;
        logic        noise_on;
        logic [11:0] noise_reload;
        logic        modulator_on;
        logic [1:0]  modulator_mode;
    } rsp_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_COMMIT,
        ST_REPLY
    } wpsg_state_t;

    typedef struct packed {
        logic capture;
        logic read;
        logic commit;
    } wpsg_cmd_t;

endpackage

// File: rtl/core/wpsg_ctrl.sv
module wpsg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output wpsg_pkg::wpsg_cmd_t cmd
);
    import wpsg_pkg::*;

    wpsg_state_t state_reg;
    wpsg_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence one word: capture, read wave RAM, commit, reply
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        req_stall   = 1'b1;
        rsp_valid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_REPLY;
            end
            ST_REPLY:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/wpsg_datapath.sv
module wpsg_datapath #(
    parameter int NUM_CHANNELS = 6,
    parameter int WAVE_DEPTH   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wpsg_pkg::wpsg_cmd_t cmd,
    input  wpsg_pkg::req_word_t req_word,
    output wpsg_pkg::rsp_word_t rsp_word
);
    import wpsg_pkg::*;

    localparam int CH_W      = $clog2(NUM_CHANNELS);
    localparam int POS_W     = $clog2(WAVE_DEPTH);
    localparam int MEM_DEPTH = NUM_CHANNELS * WAVE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    function automatic logic [POS_W-1:0] pos_inc(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        if (p == POS_W'(WAVE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + POS_W'(1);
        end
        return r;
    endfunction

    function automatic logic [4:0] low5(input logic [POS_W-1:0] p);
        logic [31:0] t;
        t = 32'(p);
        return t[4:0];
    endfunction

    // Captured word
    logic [3:0]  addr_reg;
    logic [7:0]  data_reg;

    // Global and per-channel state
    logic [2:0]       sel_reg;
    logic [1:0]       lfo_mode_reg;
    logic             lfo_on_reg;
    logic             touched_reg;
    logic             touched_next;
    logic [11:0]      period_reg [NUM_CHANNELS];
    logic [POS_W-1:0] pos_reg    [NUM_CHANNELS];
    logic [4:0]       sample_reg [NUM_CHANNELS];
    logic [4:0]       vol_reg    [NUM_CHANNELS];
    logic             en_reg     [NUM_CHANNELS];
    logic             dir_reg    [NUM_CHANNELS];
    logic             noise_on_reg    [2];
    logic [11:0]      noise_count_reg [2];

    // Wave RAM with one valid bit per entry
    logic [4:0]           wave_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] wave_vld_reg;
    logic [4:0]           rd_data_reg;
    logic                 rd_hit_reg;

    logic            ch_ok;
    logic            noisy;
    logic [CH_W-1:0] ch;
    logic            nz;
    logic            d6;
    logic            d7;
    logic            rewind;
    logic            step;
    logic [POS_W-1:0] new_pos;
    logic [CH_W-1:0]  rd_ch;
    logic [POS_W-1:0] rd_pos;
    logic [MEM_AW-1:0] rd_idx;
    logic [MEM_AW-1:0] wr_idx;
    logic [4:0]       ram_sample;
    logic             wr_en;

    // Decode the selected channel and the control write
    always_comb
    begin
        ch_ok   = 32'(sel_reg) < NUM_CHANNELS;
        ch      = sel_reg[CH_W-1:0];
        noisy   = ch_ok && (32'(sel_reg) >= NUM_CHANNELS - 2);
        nz      = (ch == CH_W'(NUM_CHANNELS - 1));
        d6      = data_reg[6];
        d7      = data_reg[7];
        rewind  = dir_reg[ch] && !d6;
        step    = !en_reg[ch] && d7 && !d6;
        new_pos = rewind ? '0 : pos_reg[ch];
        if (step)
        begin
            new_pos = pos_inc(new_pos);
        end
        if (addr_reg == ADDR_LFO_CTRL)
        begin
            rd_ch  = CH_W'(1);
            rd_pos = '0;
        end
        else
        begin
            rd_ch  = ch;
            rd_pos = new_pos;
        end
        rd_idx     = MEM_AW'(rd_ch) * MEM_AW'(WAVE_DEPTH) + MEM_AW'(rd_pos);
        wr_idx     = MEM_AW'(ch) * MEM_AW'(WAVE_DEPTH) + MEM_AW'(pos_reg[ch]);
        ram_sample = rd_hit_reg ? rd_data_reg : 5'd0;
        wr_en      = cmd.commit && (addr_reg == ADDR_WAVE_DATA) && ch_ok && !dir_reg[ch];
        touched_next = (ch_ok && (addr_reg inside {ADDR_FREQ_LO, ADDR_FREQ_HI, ADDR_CONTROL,
                                                   ADDR_CHAN_BAL, ADDR_WAVE_DATA}))
                       || (noisy && (addr_reg == ADDR_NOISE));
    end

    // Read and write the wave RAM
    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            rd_data_reg <= wave_mem[rd_idx];
        end
        if (wr_en)
        begin
            wave_mem[wr_idx] <= data_reg[4:0];
        end
    end

    // Track written entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_vld_reg <= '0;
            rd_hit_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.read)
            begin
                rd_hit_reg <= wave_vld_reg[rd_idx];
            end
            if (wr_en)
            begin
                wave_vld_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // Capture the word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= req_word.reg_address;
            data_reg <= req_word.write_data;
        end
    end

    // Commit the register write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg      <= '0;
            lfo_mode_reg <= '0;
            lfo_on_reg   <= 1'b0;
            touched_reg  <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                period_reg[i] <= '0;
                pos_reg[i]    <= '0;
                sample_reg[i] <= '0;
                vol_reg[i]    <= '0;
                en_reg[i]     <= 1'b0;
                dir_reg[i]    <= 1'b0;
            end
            for (int i = 0; i < 2; i++)
            begin
                noise_on_reg[i]    <= 1'b0;
                noise_count_reg[i] <= '0;
            end
        end
        else if (cmd.commit)
        begin
            touched_reg <= touched_next;
            case (addr_reg)
                ADDR_SELECT:
                begin
                    sel_reg <= data_reg[2:0];
                end
                ADDR_FREQ_LO:
                begin
                    if (ch_ok)
                    begin
                        period_reg[ch] <= {period_reg[ch][11:8], data_reg};
                    end
                end
                ADDR_FREQ_HI:
                begin
                    if (ch_ok)
                    begin
                        period_reg[ch] <= {data_reg[3:0], period_reg[ch][7:0]};
                    end
                end
                ADDR_CONTROL:
                begin
                    if (ch_ok)
                    begin
                        pos_reg[ch] <= new_pos;
                        if (rewind || step)
                        begin
                            sample_reg[ch] <= ram_sample;
                        end
                        vol_reg[ch] <= data_reg[4:0];
                        en_reg[ch]  <= d7;
                        dir_reg[ch] <= d6;
                    end
                end
                ADDR_WAVE_DATA:
                begin
                    if (ch_ok)
                    begin
                        if (!dir_reg[ch] && !en_reg[ch])
                        begin
                            pos_reg[ch] <= pos_inc(pos_reg[ch]);
                        end
                        if (en_reg[ch])
                        begin
                            sample_reg[ch] <= data_reg[4:0];
                        end
                    end
                end
                ADDR_NOISE:
                begin
                    if (noisy)
                    begin
                        if (!noise_on_reg[nz] && d7)
                        begin
                            noise_count_reg[nz] <= 12'(~data_reg[4:0]) << NOISE_SHIFT;
                        end
                        noise_on_reg[nz] <= d7;
                    end
                end
                ADDR_LFO_CTRL:
                begin
                    lfo_mode_reg <= data_reg[1:0];
                    lfo_on_reg   <= d7;
                    if (d7)
                    begin
                        pos_reg[1]    <= '0;
                        sample_reg[1] <= ram_sample;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Build the snapshot of the selected channel
    always_comb
    begin
        rsp_word                  = '0;
        rsp_word.selected_channel = sel_reg;
        rsp_word.channel_touched  = touched_reg;
        rsp_word.modulator_on     = lfo_on_reg;
        rsp_word.modulator_mode   = lfo_mode_reg;
        if (ch_ok)
        begin
            rsp_word.current_sample = sample_reg[ch];
            rsp_word.wave_index     = low5(pos_reg[ch]);
            rsp_word.period_value   = period_reg[ch];
            rsp_word.channel_volume = vol_reg[ch];
            rsp_word.play_enable    = en_reg[ch];
            rsp_word.direct_mode    = dir_reg[ch];
        end
        if (noisy)
        begin
            rsp_word.noise_on     = noise_on_reg[nz];
            rsp_word.noise_reload = noise_count_reg[nz];
        end
    end

endmodule

// File: rtl/core/wavetable_psg_register_write.sv
// Register write port of a wavetable sound generator.
// Request channel (req_valid, req_stall, req_word) carries one bus write:
// a 4-bit register address and a data byte. Response channel (rsp_valid,
// rsp_stall, rsp_word) returns one snapshot of the selected channel per
// write, after the write has taken effect.
// A word is taken when valid is high and stall is low at a rising edge.
// Sequence: the request is captured, the wave RAM is read, the write is
// committed, and then rsp_valid rises in the reply state. A new write is
// not taken until the response of the last one is taken; the wave RAM read
// and its registered data add a state to each write.
// While a write is in flight or its response waits, req_stall stays high.
// When rsp_stall is high the response holds unchanged until it is taken.
// Reset clears the select, LFO settings, all channel registers and the
// valid bits of the wave RAM, so unwritten samples read as zero; no clearing
// pass is needed and a request can be taken as soon as reset is released.
module wavetable_psg_register_write #(
    parameter int NUM_CHANNELS = 6,
    parameter int WAVE_DEPTH   = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  wpsg_pkg::req_word_t req_word,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output wpsg_pkg::rsp_word_t rsp_word
);
    import wpsg_pkg::*;

    wpsg_cmd_t cmd;

    wpsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    wpsg_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .WAVE_DEPTH   (WAVE_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_word (req_word),
        .rsp_word (rsp_word)
    );

endmodule

// File: rtl/core/wpsg_checker.sv
module wpsg_checker #(
    parameter int NUM_CHANNELS = 6
) (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_stall,
    input wpsg_pkg::req_word_t req_word,
    input logic                rsp_valid,
    input logic                rsp_stall,
    input wpsg_pkg::rsp_word_t rsp_word
);
    import wpsg_pkg::*;

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
        else $error("stalled response changed");

    // A stalled request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_stall |=> req_valid && $stable(req_word))
        else $error("stalled request changed");

    // A taken request blocks the next one
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while busy");

    // No request is taken while a response waits
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> req_stall)
        else $error("request port open with response pending");

    // Channel fields read zero beyond the channels
    a_empty_select: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (32'(rsp_word.selected_channel) >= NUM_CHANNELS) |->
        rsp_word.channel_touched == 1'b0 && rsp_word.period_value == 12'd0 &&
        rsp_word.noise_reload == 12'd0 && rsp_word.current_sample == 5'd0)
        else $error("unselected channel shows data");

endmodule

bind wavetable_psg_register_write wpsg_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_wpsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_word  (req_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
